// ----- design/greedy_interval_cover_assert.svh -----
// ----------------------------------------------------------------------------
// greedy_interval_cover_assert.svh
// assertion macros used by the cover block checker
// ----------------------------------------------------------------------------
`ifndef GREEDY_INTERVAL_COVER_ASSERT_SVH
`define GREEDY_INTERVAL_COVER_ASSERT_SVH

// same-cycle implication, sampled on clk_i, off during reset
`define GIC_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("cover block assertion failed");

// next-cycle implication, sampled on clk_i, off during reset
`define GIC_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("cover block assertion failed");

`endif

// ----- design/gic_pkg.sv -----
// ----------------------------------------------------------------------------
// gic_pkg
// types, sizes and compare helpers of the greedy interval cover block
// ----------------------------------------------------------------------------
`default_nettype none

package gic_pkg;

  localparam int MAX_SEGMENTS = 32;
  localparam int COORD_BITS   = 16;
  localparam int TGT_W        = 15;
  localparam int IDX_W        = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
  localparam int CNT_W        = $clog2(MAX_SEGMENTS + 1);
  localparam int CMP_W        = ((COORD_BITS > TGT_W) ? COORD_BITS : TGT_W) + 1;

  typedef logic signed [COORD_BITS-1:0] coord_t;

  typedef struct packed {
    coord_t seg_left;
    coord_t seg_right;
    logic   last_segment;
  } item_t;

  typedef struct packed {
    logic             is_header;
    logic [CNT_W-1:0] chosen_count;
    coord_t           out_left;
    coord_t           out_right;
    logic             last_result;
  } result_t;

  typedef struct packed {
    coord_t left;
    coord_t right;
  } seg_t;

  typedef struct packed {
    logic valid;
    seg_t seg;
  } cell_t;

  // what a cell hands to its right neighbor
  typedef struct packed {
    cell_t c;
    logic  ins;
  } link_t;

  typedef enum logic [1:0] {
    CMD_HOLD,
    CMD_INSERT,
    CMD_SHIFT,
    CMD_CLEAR
  } cell_cmd_e;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_WALK_A,
    ST_START,
    ST_WALK_B,
    ST_HDR,
    ST_EMIT
  } state_e;

  localparam coord_t COORD_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
  localparam coord_t COORD_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};

  // a goes ahead of b: ascending left end, then descending right end
  function automatic logic seg_before(seg_t a, seg_t b);
    seg_before = (a.left < b.left) || ((a.left == b.left) && (a.right > b.right));
  endfunction

  // coordinate reaches the target
  function automatic logic reaches(coord_t r, logic [TGT_W-1:0] t);
    logic signed [CMP_W-1:0] a;
    logic signed [CMP_W-1:0] b;
    a = CMP_W'(r);
    b = $signed(CMP_W'(t));
    reaches = (a >= b);
  endfunction

endpackage

`default_nettype wire

// ----- design/greedy_interval_cover.sv -----
// ----------------------------------------------------------------------------
// greedy_interval_cover
// fewest segments covering [0, target_length], found by a greedy walk
// ----------------------------------------------------------------------------
// Segments are taken one per cycle while busy_o is low; each lands in a
// chain of MAX_SEGMENTS cells that keeps them sorted as they arrive, and a
// segment arriving while the chain is full is dropped. The segment marked
// last_segment raises busy_o. The walk then shifts the chain out through its
// head cell, one segment per cycle, and stops early once the target is
// reached or a gap is found. A header with the count follows, then one
// result per chosen segment on consecutive cycles, read from a small ram of
// chosen segments. Each result is shown for one cycle under valid_o and
// cannot be held off. The target_length register may be written whenever
// the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module greedy_interval_cover (
  input  wire                        clk_i,
  input  wire                        rst_ni,
  input  wire                        start_i,
  output logic                       busy_o,
  input  gic_pkg::item_t             item_i,
  output logic                       valid_o,
  output gic_pkg::result_t           result_o,
  input  wire                        cfg_we_i,
  input  wire  [gic_pkg::TGT_W-1:0]  cfg_wdata_i
);
  import gic_pkg::*;

  state_e state_q, state_d;
  logic [TGT_W-1:0] tgt_q;
  coord_t min_l_q, min_l_d, max_r_q, max_r_d;
  coord_t min_l_nx, max_r_nx;
  logic best_v_q, best_v_d;
  seg_t cand_q, cand_d;
  coord_t prev_r_q, prev_r_d;
  logic [IDX_W-1:0] slot_q, slot_d, idx_q, idx_d, slot_nx;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic res_v_d, res_v_q;
  result_t res_d, res_q;

  cell_cmd_e cmd;
  seg_t new_seg;
  link_t links [MAX_SEGMENTS];
  cell_t head;
  logic full, take, store;

  logic ram_we;
  logic [IDX_W-1:0] ram_waddr, ram_raddr;
  seg_t ram_wdata, ram_rdata;

  assign new_seg.left  = item_i.seg_left;
  assign new_seg.right = item_i.seg_right;
  assign head  = links[0].c;
  assign full  = links[MAX_SEGMENTS-1].c.valid;
  assign take  = start_i && (state_q == ST_LOAD);
  assign store = take && !full;

  // set extremes including the segment stored in this cycle
  assign min_l_nx = (store && (new_seg.left < min_l_q)) ? new_seg.left : min_l_q;
  assign max_r_nx = (store && (new_seg.right > max_r_q)) ? new_seg.right : max_r_q;

  // sorting chain
  for (genvar i = 0; i < MAX_SEGMENTS; i++) begin : g_cell
    link_t prev;
    cell_t next;
    if (i == 0) begin : g_first
      assign prev = '0;
    end else begin : g_mid
      assign prev = links[i-1];
    end
    if (i == MAX_SEGMENTS - 1) begin : g_last
      assign next = '0;
    end else begin : g_inner
      assign next = links[i+1].c;
    end
    gic_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .cmd_i  (cmd),
      .new_i  (new_seg),
      .prev_i (prev),
      .next_i (next),
      .link_o (links[i])
    );
  end

  // chosen segments
  gic_ram #(
    .WIDTH ($bits(seg_t)),
    .DEPTH (MAX_SEGMENTS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign slot_nx = (prev_r_q < head.seg.left) ? slot_q + 1'b1 : slot_q;

  // sequencer
  always_comb begin
    state_d   = state_q;
    min_l_d   = min_l_q;
    max_r_d   = max_r_q;
    best_v_d  = best_v_q;
    cand_d    = cand_q;
    prev_r_d  = prev_r_q;
    slot_d    = slot_q;
    idx_d     = idx_q;
    cnt_d     = cnt_q;
    cmd       = CMD_HOLD;
    ram_we    = 1'b0;
    ram_waddr = slot_q;
    ram_wdata = head.seg;
    ram_raddr = idx_q + 1'b1;
    res_v_d   = 1'b0;
    res_d     = '0;
    case (state_q)
      ST_LOAD: begin
        if (store) begin
          cmd     = CMD_INSERT;
          min_l_d = min_l_nx;
          max_r_d = max_r_nx;
        end
        if (take && item_i.last_segment) begin
          best_v_d = 1'b0;
          min_l_d  = COORD_MAX;
          max_r_d  = COORD_MIN;
          cnt_d    = '0;
          // pre-check on the extremes of the set
          if ((min_l_nx > 0) || !reaches(max_r_nx, tgt_q)) begin
            state_d = ST_HDR;
          end else begin
            state_d = ST_WALK_A;
          end
        end
      end
      ST_WALK_A: begin
        // farthest reach among segments starting at or below zero
        if (head.valid && (head.seg.left <= 0)) begin
          cmd = CMD_SHIFT;
          if (!best_v_q || (head.seg.right > cand_q.right)) begin
            best_v_d = 1'b1;
            cand_d   = head.seg;
          end
        end else begin
          state_d = ST_START;
        end
      end
      ST_START: begin
        ram_waddr = '0;
        ram_wdata = cand_q;
        if (!best_v_q) begin
          state_d = ST_HDR;
        end else begin
          ram_we = 1'b1;
          if (reaches(cand_q.right, tgt_q)) begin
            cnt_d   = CNT_W'(1);
            state_d = ST_HDR;
          end else begin
            slot_d   = IDX_W'(1);
            prev_r_d = cand_q.right;
            state_d  = ST_WALK_B;
          end
        end
      end
      ST_WALK_B: begin
        if (!head.valid || (head.seg.left > cand_q.right)) begin
          state_d = ST_HDR;
        end else begin
          cmd = CMD_SHIFT;
          if (head.seg.right > cand_q.right) begin
            // extend the reach, opening a new slot when the last one is passed
            if (prev_r_q < head.seg.left) prev_r_d = cand_q.right;
            slot_d    = slot_nx;
            cand_d    = head.seg;
            ram_we    = 1'b1;
            ram_waddr = slot_nx;
            if (reaches(head.seg.right, tgt_q)) begin
              cnt_d   = CNT_W'(slot_nx) + 1'b1;
              state_d = ST_HDR;
            end
          end
        end
      end
      ST_HDR: begin
        cmd                = CMD_CLEAR;
        ram_raddr          = '0;
        idx_d              = '0;
        res_v_d            = 1'b1;
        res_d.is_header    = 1'b1;
        res_d.chosen_count = cnt_q;
        res_d.last_result  = (cnt_q == '0);
        state_d            = (cnt_q == '0) ? ST_LOAD : ST_EMIT;
      end
      ST_EMIT: begin
        res_v_d            = 1'b1;
        res_d.chosen_count = cnt_q;
        res_d.out_left     = ram_rdata.left;
        res_d.out_right    = ram_rdata.right;
        res_d.last_result  = (CNT_W'(idx_q) + 1'b1 == cnt_q);
        idx_d              = idx_q + 1'b1;
        if (res_d.last_result) state_d = ST_LOAD;
      end
      default: state_d = ST_LOAD;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_LOAD;
      tgt_q    <= TGT_W'(1);
      min_l_q  <= COORD_MAX;
      max_r_q  <= COORD_MIN;
      best_v_q <= 1'b0;
      res_v_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      min_l_q  <= min_l_d;
      max_r_q  <= max_r_d;
      best_v_q <= best_v_d;
      res_v_q  <= res_v_d;
      if (cfg_we_i) tgt_q <= cfg_wdata_i;
    end
  end

  // walk and output payload
  always_ff @(posedge clk_i) begin
    cand_q   <= cand_d;
    prev_r_q <= prev_r_d;
    slot_q   <= slot_d;
    idx_q    <= idx_d;
    cnt_q    <= cnt_d;
    res_q    <= res_d;
  end

  assign busy_o   = (state_q != ST_LOAD);
  assign valid_o  = res_v_q;
  assign result_o = res_q;

endmodule

`default_nettype wire

// ----- design/gic_cell.sv -----
// ----------------------------------------------------------------------------
// gic_cell
// one slot of the sorting chain: insert in order, shift toward the head
// ----------------------------------------------------------------------------
`default_nettype none

module gic_cell (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  gic_pkg::cell_cmd_e   cmd_i,
  input  gic_pkg::seg_t        new_i,
  input  gic_pkg::link_t       prev_i,
  input  gic_pkg::cell_t       next_i,
  output gic_pkg::link_t       link_o
);
  import gic_pkg::*;

  logic valid_q, valid_d;
  seg_t seg_q, seg_d;
  logic ins;

  // new segment belongs at or before this slot
  assign ins = !valid_q || seg_before(new_i, seg_q);

  // next contents
  always_comb begin
    valid_d = valid_q;
    seg_d   = seg_q;
    case (cmd_i)
      CMD_INSERT: begin
        if (ins) begin
          if (prev_i.ins) begin
            valid_d = prev_i.c.valid;
            seg_d   = prev_i.c.seg;
          end else begin
            valid_d = 1'b1;
            seg_d   = new_i;
          end
        end
      end
      CMD_SHIFT: begin
        valid_d = next_i.valid;
        seg_d   = next_i.seg;
      end
      CMD_CLEAR: valid_d = 1'b0;
      default: ;
    endcase
  end

  // valid bit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    seg_q <= seg_d;
  end

  assign link_o.c.valid = valid_q;
  assign link_o.c.seg   = seg_q;
  assign link_o.ins     = ins;

endmodule

`default_nettype wire

// ----- design/gic_ram.sv -----
// ----------------------------------------------------------------------------
// gic_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module gic_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  wire                                         clk_i,
  input  wire                                         we_i,
  input  wire  [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire  [WIDTH-1:0]                            wdata_i,
  input  wire  [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                            rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

`default_nettype wire

// ----- design/gic_checker.sv -----
// ----------------------------------------------------------------------------
// gic_checker
// port-level checks of the cover block result stream
// ----------------------------------------------------------------------------
`default_nettype none

`include "greedy_interval_cover_assert.svh"

module gic_checker (
  input wire                       clk_i,
  input wire                       rst_ni,
  input wire                       start_i,
  input wire                       busy_o,
  input gic_pkg::item_t            item_i,
  input wire                       valid_o,
  input gic_pkg::result_t          result_o,
  input wire                       cfg_we_i,
  input wire [gic_pkg::TGT_W-1:0]  cfg_wdata_i
);
  import gic_pkg::*;

  logic last_take;
  logic unused_cfg;

  assign last_take  = start_i && !busy_o && item_i.last_segment;
  assign unused_cfg = cfg_we_i ^ (^cfg_wdata_i);

  // a segment result only exists in a run that found a cover
  `GIC_ASSERT_IMP(a_seg_has_count, valid_o && !result_o.is_header,
                  result_o.chosen_count != '0)
  // the header carries no coordinates
  `GIC_ASSERT_IMP(a_hdr_zero, valid_o && result_o.is_header,
                  (result_o.out_left == '0) && (result_o.out_right == '0))
  // the final segment transfer starts the run
  `GIC_ASSERT_NXT(a_last_busy, last_take, busy_o)
  // a header that is not final is followed at once by a segment
  `GIC_ASSERT_NXT(a_hdr_follow, valid_o && result_o.is_header && !result_o.last_result,
                  valid_o && !result_o.is_header)
  // nothing comes right after the final result
  `GIC_ASSERT_NXT(a_end_quiet, valid_o && result_o.last_result, !valid_o)

endmodule

bind greedy_interval_cover gic_checker u_gic_checker (.*);

`default_nettype wire
